// ===== rtl/rpm_pkg.sv =====
// Shared types, codes and helpers for the reply pattern matcher.
package rpm_pkg;

  localparam int BYTE_W       = 8;
  localparam int PAT_W        = 64;
  localparam int PAT_MAX      = 8;   // bytes held by the pattern register
  localparam int CNT_W        = 4;
  localparam int POS_W        = 16;
  localparam int LIMIT_W      = 8;
  localparam int HEX_W        = 32;
  localparam int NIB_W        = 4;
  localparam int MODE_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 40;

  localparam int PATTERN_BYTES_DEF  = 8;
  localparam int HEX_DIGITS_MAX_DEF = 8;

  // search modes
  localparam logic [MODE_W-1:0] MODE_WHOLE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_STOP   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HEXRUN = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WINDOW = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HEXCAP = 3'd4;

  // result status
  localparam logic [STATUS_W-1:0] ST_MATCH     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_HEX_OK    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_HEX_SHORT = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP    = 3'd5;

  // ASCII offsets for digit conversion
  localparam logic [BYTE_W-1:0] DIGIT_OFS = 8'd48;
  localparam logic [BYTE_W-1:0] UPPER_OFS = 8'd55;
  localparam logic [BYTE_W-1:0] LOWER_OFS = 8'd87;

  typedef struct packed {
    logic [CNT_W-1:0]    hex_count;
    logic [HEX_W-1:0]    hex_value;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic             valid;
    logic [NIB_W-1:0] value;
  } nibble_t;

  function automatic nibble_t hex_nibble(input logic [BYTE_W-1:0] c);
    nibble_t    r;
    logic [BYTE_W-1:0] d;
    r = '0;
    d = '0;
    if (c >= "0" && c <= "9") begin
      d = c - DIGIT_OFS;
      r.valid = 1'b1;
    end else if (c >= "A" && c <= "F") begin
      d = c - UPPER_OFS;
      r.valid = 1'b1;
    end else if (c >= "a" && c <= "f") begin
      d = c - LOWER_OFS;
      r.valid = 1'b1;
    end
    r.value = d[NIB_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/rpm_cell.sv =====
// One window cell: holds one recent byte, passes it on, compares the incoming byte.
module rpm_cell
  import rpm_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic [BYTE_W-1:0] want,
  output logic [BYTE_W-1:0] byte_out,
  output logic              eq
);

  logic [BYTE_W-1:0] held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= byte_in;
    end
  end

  // compare against the byte this cell holds after the shift
  assign eq       = (byte_in == want);
  assign byte_out = held;

endmodule

// ===== rtl/rpm_out_buf.sv =====
// Two-entry result queue between the matcher and the output channel.
module rpm_out_buf
  import rpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  result_t               push_data,
  output logic                  full,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata  // status[1:0], hex_value[33:2], hex_count[37:34]
);

  result_t    entry [2];
  logic [1:0] count;
  logic       pop;
  logic       wsel;

  assign pop  = m_axis_tvalid && m_axis_tready;
  assign wsel = (count == 2'd2) || (count == 2'd1 && !pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // head takes a new item when it lands there, else the second entry moves up
  always_ff @(posedge clk) begin
    if (push && !wsel) begin
      entry[0] <= push_data;
    end else if (pop) begin
      entry[0] <= entry[1];
    end
    if (push && wsel) begin
      entry[1] <= push_data;
    end
  end

  assign full          = (count == 2'd2);
  assign m_axis_tvalid = (count != 2'd0);
  assign m_axis_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), entry[0]};

endmodule

// ===== rtl/reply_pattern_matcher.sv =====
// Top level of the reply pattern matcher: registers, search control and window chain.
//
// Reply bytes enter on the s_axis channel, one per item, with tlast on the
// final byte of a string. Each string gives exactly one status item on the
// m_axis channel: on the byte that decides it, or on the last byte. The user writes
// registers (cfg_we / cfg_index / cfg_data) only while idle; the block does not enforce it.
//
// Throughput: one byte per cycle while the result queue is not full. The
// window is a row of byte cells that shift once per accepted byte the mode
// pushes in; each cell compares the byte it receives with its pattern byte,
// and one AND across the row plus the mode counters settle the result in the
// same cycle. A result is registered in the output queue before m_axis sees it.
// Results wait in a two-entry queue; s_axis_tready drops only while both
// entries are full, so a stalled receiver holds back input after two results.
// Reset (rst, synchronous) returns registers to their defaults (mode 0,
// pattern length 1, the rest zero), clears the search state and empties the
// queue.
module reply_pattern_matcher
  import rpm_pkg::*;
#(
  parameter int PATTERN_BYTES  = PATTERN_BYTES_DEF,
  parameter int HEX_DIGITS_MAX = HEX_DIGITS_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic                  s_axis_tlast,   // last_byte
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // status[1:0], hex_value[33:2], hex_count[37:34]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [PAT_W-1:0]      cfg_data
);

  localparam int CELLS = (PATTERN_BYTES < PAT_MAX) ? PATTERN_BYTES : PAT_MAX;
  localparam logic [CNT_W-1:0] CELLS_C = CNT_W'(CELLS);
  localparam logic [CNT_W-1:0] HEX_MAX = CNT_W'(HEX_DIGITS_MAX);

  // registers
  logic [MODE_W-1:0]  search_mode;
  logic [PAT_W-1:0]   pattern;
  logic [CNT_W-1:0]   pattern_length;
  logic [POS_W-1:0]   start_offset;
  logic [LIMIT_W-1:0] window_limit;
  logic [BYTE_W-1:0]  stop_char;

  // search state
  logic [CNT_W-1:0]   window_fill;
  logic [POS_W-1:0]   byte_position;
  logic [LIMIT_W-1:0] examined_count;
  logic [HEX_W-1:0]   hex_accumulator;
  logic [CNT_W-1:0]   hex_digits_seen;
  logic               decided;

  logic [LIMIT_W-1:0] examined_count_next;
  logic [HEX_W-1:0]   hex_accumulator_next;
  logic [CNT_W-1:0]   hex_digits_seen_next;
  logic [CNT_W-1:0]   window_fill_next;

  logic               accept;
  logic               out_full;
  logic [BYTE_W-1:0]  data_byte;
  logic               last_byte;
  logic [CNT_W-1:0]   used_len;
  logic [CNT_W-1:0]   hex_lim;
  logic               in_zone;
  logic               push;
  logic               match;
  logic               emit;
  result_t            res;
  nibble_t            nib;

  logic [BYTE_W-1:0]  chain_in [CELLS];
  logic [BYTE_W-1:0]  chain_out[CELLS];
  logic [BYTE_W-1:0]  want     [CELLS];
  logic [CELLS-1:0]   eq;
  logic [CELLS-1:0]   used;

  assign data_byte     = s_axis_tdata[BYTE_W-1:0];
  assign last_byte     = s_axis_tlast;
  assign s_axis_tready = !out_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_mode    <= MODE_WHOLE;
      pattern        <= '0;
      pattern_length <= CNT_W'(1);
      start_offset   <= '0;
      window_limit   <= '0;
      stop_char      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:    search_mode    <= cfg_data[MODE_W-1:0];
        REG_PATTERN: pattern        <= cfg_data;
        REG_PAT_LEN: pattern_length <= cfg_data[CNT_W-1:0];
        REG_OFFSET:  start_offset   <= cfg_data[POS_W-1:0];
        REG_LIMIT:   window_limit   <= cfg_data[LIMIT_W-1:0];
        REG_STOP:    stop_char      <= cfg_data[BYTE_W-1:0];
        default:     ;
      endcase
    end
  end

  // effective pattern length, clamped to 1..CELLS
  always_comb begin
    used_len = pattern_length;
    if (used_len == '0) begin
      used_len = CNT_W'(1);
    end else if (used_len > CELLS_C) begin
      used_len = CELLS_C;
    end
  end

  assign hex_lim = (window_limit > LIMIT_W'(HEX_MAX)) ? HEX_MAX : window_limit[CNT_W-1:0];

  // window chain: cell 0 takes the newest byte, cell j lines up with pattern byte len-1-j
  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    logic [CNT_W-1:0] pidx;
    assign pidx    = used_len - CNT_W'(j) - CNT_W'(1);
    assign want[j] = pattern[{pidx[2:0], 3'b000} +: BYTE_W];
    assign used[j] = (CNT_W'(j) < used_len);
    if (j == 0) begin : g_head
      assign chain_in[j] = data_byte;
    end else begin : g_link
      assign chain_in[j] = chain_out[j-1];
    end
    rpm_cell u_cell (
      .clk      (clk),
      .shift    (accept && push),
      .byte_in  (chain_in[j]),
      .want     (want[j]),
      .byte_out (chain_out[j]),
      .eq       (eq[j])
    );
  end

  assign window_fill_next = (window_fill < CELLS_C) ? window_fill + CNT_W'(1) : window_fill;
  assign match = (window_fill_next >= used_len) && (&(eq | ~used));
  assign in_zone = (byte_position >= start_offset);
  assign nib = hex_nibble(data_byte);

  always_comb begin
    emit                 = 1'b0;
    push                 = 1'b0;
    res.status           = ST_NOT_FOUND;
    examined_count_next  = examined_count;
    hex_accumulator_next = hex_accumulator;
    hex_digits_seen_next = hex_digits_seen;
    if (!decided) begin
      unique case (search_mode)
        MODE_WHOLE: begin
          push = 1'b1;
          if (match) begin
            emit       = 1'b1;
            res.status = ST_MATCH;
          end
        end
        MODE_STOP: begin
          if (data_byte == stop_char) begin
            emit = 1'b1;
          end else begin
            push = 1'b1;
            if (match) begin
              emit       = 1'b1;
              res.status = ST_MATCH;
            end
          end
        end
        MODE_HEXRUN: begin
          if (in_zone) begin
            if (!nib.valid) begin
              emit = 1'b1;
            end else begin
              push = 1'b1;
              if (match) begin
                emit       = 1'b1;
                res.status = ST_MATCH;
              end
            end
          end
        end
        MODE_WINDOW: begin
          if (in_zone) begin
            if (examined_count >= window_limit) begin
              emit = 1'b1;
            end else begin
              push                = 1'b1;
              examined_count_next = examined_count + LIMIT_W'(1);
              if (match) begin
                emit       = 1'b1;
                res.status = ST_MATCH;
              end else if (examined_count_next >= window_limit) begin
                emit = 1'b1;
              end
            end
          end
        end
        MODE_HEXCAP: begin
          if (in_zone) begin
            if (hex_digits_seen >= hex_lim) begin
              emit       = 1'b1;
              res.status = ST_HEX_OK;
            end else if (!nib.valid) begin
              emit       = 1'b1;
              res.status = ST_HEX_SHORT;
            end else begin
              hex_accumulator_next = {hex_accumulator[HEX_W-NIB_W-1:0], nib.value};
              hex_digits_seen_next = hex_digits_seen + CNT_W'(1);
              if (hex_digits_seen_next >= hex_lim) begin
                emit       = 1'b1;
                res.status = ST_HEX_OK;
              end
            end
          end
        end
        default: ;
      endcase
      if (!emit && last_byte) begin
        emit       = 1'b1;
        res.status = (search_mode == MODE_HEXCAP) ? ST_HEX_SHORT : ST_NOT_FOUND;
      end
    end
    res.hex_value = (search_mode == MODE_HEXCAP) ? hex_accumulator_next : '0;
    res.hex_count = (search_mode == MODE_HEXCAP) ? hex_digits_seen_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill     <= '0;
      byte_position   <= '0;
      examined_count  <= '0;
      hex_accumulator <= '0;
      hex_digits_seen <= '0;
      decided         <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        window_fill     <= '0;
        byte_position   <= '0;
        examined_count  <= '0;
        hex_accumulator <= '0;
        hex_digits_seen <= '0;
        decided         <= 1'b0;
      end else begin
        if (push) begin
          window_fill <= window_fill_next;
        end
        if (byte_position != '1) begin
          byte_position <= byte_position + POS_W'(1);
        end
        examined_count  <= examined_count_next;
        hex_accumulator <= hex_accumulator_next;
        hex_digits_seen <= hex_digits_seen_next;
        decided         <= decided || emit;
      end
    end
  end

  rpm_out_buf u_out_buf (
    .clk           (clk),
    .rst           (rst),
    .push          (accept && emit),
    .push_data     (res),
    .full          (out_full),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // end of string returns the search to its open state
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> !decided && byte_position == '0 && window_fill == '0)
    else $error("search state not cleared after last byte");

  // a decided string never produces a second result
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    decided |-> !emit)
    else $error("second result for one string");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    window_fill <= CELLS_C && hex_digits_seen <= HEX_MAX)
    else $error("window fill or digit count out of range");

endmodule
